@@ rtl/celtic_mandelbrot_escape_time_assert.svh @@
// ----------------------------------------------------------------------------
// Celtic Mandelbrot escape-time assertion macros
// Checks that simulation sees and synthesis leaves out.
// ----------------------------------------------------------------------------
`ifndef CELTIC_MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define CELTIC_MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, off while reset is high.
`define CMET_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmet assertion failed");
// Next-cycle implication, off while reset is high.
`define CMET_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmet assertion failed");
`else
`define CMET_ASSERT_IMP(name, clk, rst, ante, cons)
`define CMET_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cmet_pkg.sv @@
// ----------------------------------------------------------------------------
// cmet_pkg
// Shared types and constants of the Celtic Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmet_pkg;

   // Operand digit that one multiplier cell handles.
   localparam int DIGIT_BITS = 16;

   localparam int INDEX_BITS = 16;
   localparam int MAG_BITS   = 40;

   // Register file.
   localparam int                    CSR_ADDR_BITS     = 3;
   localparam int                    CSR_DATA_BITS     = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_MAX_ITER = 3'd0;
   localparam logic [INDEX_BITS-1:0]    MAX_ITER_RESET    = 16'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_SEND
   } cmet_state_type;

   // Result of one update pass, as seen by the controller.
   typedef struct packed {
      logic                valid;
      logic                escaped;
      logic [MAG_BITS-1:0] mag;
   } cmet_status_type;

endpackage

`default_nettype wire

@@ rtl/cmet_cell.sv @@
// ----------------------------------------------------------------------------
// cmet_cell
// One link of the multiplier chain: adds one digit's worth of x*x, y*y, x*y.
// ----------------------------------------------------------------------------
`default_nettype none

module cmet_cell #(
   parameter int WORD_BITS = 32,
   parameter int LOW_BIT   = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     vld_in,
   input  wire logic [WORD_BITS-1:0]     ax_in,
   input  wire logic [WORD_BITS-1:0]     ay_in,
   input  wire logic [2*WORD_BITS-1:0]   sxx_in,
   input  wire logic [2*WORD_BITS-1:0]   syy_in,
   input  wire logic [2*WORD_BITS-1:0]   sxy_in,
   output logic                          vld_out,
   output logic [WORD_BITS-1:0]          ax_out,
   output logic [WORD_BITS-1:0]          ay_out,
   output logic [2*WORD_BITS-1:0]        sxx_out,
   output logic [2*WORD_BITS-1:0]        syy_out,
   output logic [2*WORD_BITS-1:0]        sxy_out
);
   import cmet_pkg::*;

   localparam int PW = 2 * WORD_BITS;
   localparam int TW = WORD_BITS + DIGIT_BITS;

   logic [WORD_BITS-1:0]  axs, ays;
   logic [DIGIT_BITS-1:0] dx, dy;
   logic [TW-1:0]         txx, tyy, txy;
   logic                  vld_ff;
   logic [WORD_BITS-1:0]  ax_ff, ay_ff;
   logic [PW-1:0]         sxx_ff, syy_ff, sxy_ff;

   always_comb begin
      axs = ax_in >> LOW_BIT;
      ays = ay_in >> LOW_BIT;
      dx  = axs[DIGIT_BITS-1:0];
      dy  = ays[DIGIT_BITS-1:0];
      txx = ax_in * dx;
      tyy = ay_in * dy;
      txy = ax_in * dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      sxx_ff <= sxx_in + (PW'(txx) << LOW_BIT);
      syy_ff <= syy_in + (PW'(tyy) << LOW_BIT);
      sxy_ff <= sxy_in + (PW'(txy) << LOW_BIT);
   end

   assign vld_out = vld_ff;
   assign ax_out  = ax_ff;
   assign ay_out  = ay_ff;
   assign sxx_out = sxx_ff;
   assign syy_out = syy_ff;
   assign sxy_out = sxy_ff;

endmodule

`default_nettype wire

@@ rtl/cmet_update.sv @@
// ----------------------------------------------------------------------------
// cmet_update
// Two-stage escape test and map step from the squares and the cross product.
// ----------------------------------------------------------------------------
`default_nettype none

module cmet_update #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 28
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          vld_in,
   input  wire logic [2*WORD_BITS-1:0]        sxx_in,
   input  wire logic [2*WORD_BITS-1:0]        syy_in,
   input  wire logic [2*WORD_BITS-1:0]        sxy_in,
   input  wire logic                          neg_in,
   input  wire logic signed [WORD_BITS-1:0]   cr_in,
   input  wire logic signed [WORD_BITS-1:0]   ci_in,
   output cmet_pkg::cmet_status_type          status,
   output logic signed [WORD_BITS-1:0]        nx_out,
   output logic signed [WORD_BITS-1:0]        ny_out
);
   import cmet_pkg::*;

   localparam int PW  = 2 * WORD_BITS;
   localparam int SW  = PW + 3;
   localparam int CW0 = (PW + 1 > 2 * FRACTION_BITS + 3) ? PW + 1 : 2 * FRACTION_BITS + 3;
   localparam int CW  = (CW0 > MAG_BITS + 1) ? CW0 : MAG_BITS + 1;

   localparam logic [CW-1:0]        FOUR     = CW'(1) << (2 * FRACTION_BITS + 2);
   localparam logic [CW-1:0]        MAG_SAT  = CW'({MAG_BITS{1'b1}});
   localparam logic signed [SW-1:0] WMAX_S   = SW'({(WORD_BITS-1){1'b1}});
   localparam logic signed [SW-1:0] WMIN_S   = ~WMAX_S;

   // Stage 1: escape compare, sum of squares, absolute difference, signed doubled product.
   logic [CW-1:0]        sum_c;
   logic [SW-1:0]        pv2;
   logic                 v1_ff, esc1_ff;
   logic [CW-1:0]        magsh1_ff;
   logic [PW-1:0]        dif1_ff;
   logic signed [SW-1:0] pv1_ff;

   // Stage 2: scale, add the constant, saturate.
   logic signed [SW-1:0]    ysh, yt, xsh, xt;
   logic                    v2_ff, esc2_ff;
   logic [MAG_BITS-1:0]     mag2_ff;
   logic signed [WORD_BITS-1:0] nx2_ff, ny2_ff;

   always_comb begin
      sum_c = CW'(sxx_in) + CW'(syy_in);
      pv2   = {2'b00, sxy_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= vld_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      esc1_ff   <= sum_c > FOUR;
      magsh1_ff <= sum_c >> FRACTION_BITS;
      dif1_ff   <= (sxx_in >= syy_in) ? sxx_in - syy_in : syy_in - sxx_in;
      pv1_ff    <= neg_in ? $signed(SW'(0) - pv2) : $signed(pv2);
   end

   always_comb begin
      ysh = pv1_ff >>> FRACTION_BITS;
      yt  = ysh + SW'(ci_in);
      xsh = $signed(SW'(dif1_ff) >> FRACTION_BITS);
      xt  = xsh + SW'(cr_in);
   end

   always_ff @(posedge clock) begin
      esc2_ff <= esc1_ff;
      mag2_ff <= (magsh1_ff > MAG_SAT) ? {MAG_BITS{1'b1}} : magsh1_ff[MAG_BITS-1:0];
      if (yt > WMAX_S) begin
         ny2_ff <= WMAX_S[WORD_BITS-1:0];
      end else if (yt < WMIN_S) begin
         ny2_ff <= WMIN_S[WORD_BITS-1:0];
      end else begin
         ny2_ff <= yt[WORD_BITS-1:0];
      end
      if (xt > WMAX_S) begin
         nx2_ff <= WMAX_S[WORD_BITS-1:0];
      end else if (xt < WMIN_S) begin
         nx2_ff <= WMIN_S[WORD_BITS-1:0];
      end else begin
         nx2_ff <= xt[WORD_BITS-1:0];
      end
   end

   assign status = '{valid: v2_ff, escaped: esc2_ff, mag: mag2_ff};
   assign nx_out = nx2_ff;
   assign ny_out = ny2_ff;

endmodule

`default_nettype wire

@@ rtl/celtic_mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// celtic_mandelbrot_escape_time
// Escape-time iterator for the Celtic Mandelbrot map in signed fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake         Contents
//   req_      in         tvalid / tready   z_real, z_imag, c_real, c_imag
//   rsp_      out        tvalid / tready   iteration_index, magnitude_squared;
//                                          escaped on tuser
//   csr_      in         APB write/read    max_iterations at byte address 0
//
// One request is in work at a time. Each pass through the map runs the
// PREP state, the start register, NCELL = ceil(WORD_BITS / 16) multiplier
// cells and the two update stages, and ends when the controller in RUN
// sees the update result. A bounded point runs one pass more than the
// iteration limit (default 256), and the next request can be accepted
// once its result has moved into the output register.
// Reset is synchronous and clears the control state and sets the limit to
// 256. A stalled result sits in the output register while the next request
// is accepted and iterated; the block waits only if a second result is
// ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module celtic_mandelbrot_escape_time #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 28
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: z_real [31:0], z_imag [63:32], c_real [95:64], c_imag [127:96]
   input  wire logic [127:0]                        req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: iteration_index [15:0], magnitude_squared [55:16]
   output logic [55:0]                              rsp_tdata,
   // tuser: escaped [0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cmet_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [cmet_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [cmet_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);
   import cmet_pkg::*;

`include "celtic_mandelbrot_escape_time_assert.svh"

   localparam int PW    = 2 * WORD_BITS;
   localparam int NCELL = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int EW    = (WORD_BITS > 32) ? WORD_BITS : 32;

   localparam logic signed [EW-1:0] WMAX_E = EW'({(WORD_BITS-1){1'b1}});
   localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;

   // Input words are sign extended and then clamped into the working word.
   function automatic logic signed [WORD_BITS-1:0] sat_in(input logic [31:0] raw);
      logic signed [EW-1:0] v;
      v = EW'($signed(raw));
      if (v > WMAX_E) begin
         return WMAX_E[WORD_BITS-1:0];
      end else if (v < WMIN_E) begin
         return WMIN_E[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // Configuration register.
   logic                  csr_wr;
   logic [INDEX_BITS-1:0] max_iter_ff;

   // Controller.
   cmet_state_type        state_ff, state_in;
   logic [INDEX_BITS-1:0] cnt_ff, cnt_in;
   logic                  start_ff, start_in;
   logic                  req_acc;
   logic                  done_esc, done_bnd;

   // Current point and constant; magnitudes and sign for the multipliers.
   logic signed [WORD_BITS-1:0] x_ff, x_in, y_ff, y_in, cr_ff, ci_ff;
   logic [WORD_BITS-1:0]        ax_ff, ay_ff;
   logic                        neg_ff;

   // Finished result waiting for the output register, and the register.
   logic                  res_load, res_esc_ff, res_esc_in;
   logic [INDEX_BITS-1:0] res_idx_ff, res_idx_in;
   logic [MAG_BITS-1:0]   res_mag_ff, res_mag_in;
   logic                  out_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_esc_ff;
   logic [INDEX_BITS-1:0] rsp_idx_ff;
   logic [MAG_BITS-1:0]   rsp_mag_ff;

   // Multiplier chain taps.
   logic [NCELL:0]         cvld;
   logic [WORD_BITS-1:0]   cax [0:NCELL];
   logic [WORD_BITS-1:0]   cay [0:NCELL];
   logic [PW-1:0]          csxx [0:NCELL];
   logic [PW-1:0]          csyy [0:NCELL];
   logic [PW-1:0]          csxy [0:NCELL];

   cmet_status_type             upd_status;
   logic signed [WORD_BITS-1:0] upd_nx, upd_ny;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_wr && csr_paddr == CSR_ADDR_MAX_ITER) begin
         max_iter_ff <= csr_pwdata[INDEX_BITS-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_ADDR_MAX_ITER: csr_prdata = CSR_DATA_BITS'(max_iter_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------- controller
   // A pass starts in PREP, where the magnitudes of the current point go
   // into the chain. When the update stages report, the controller either
   // finishes (escape seen after at least one iteration, or the limit
   // reached) or loads the new point and starts the next pass.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign done_esc   = (cnt_ff != '0) && upd_status.escaped;
   assign done_bnd   = (cnt_ff == max_iter_ff);
   assign out_load   = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      start_in   = 1'b0;
      x_in       = x_ff;
      y_in       = y_ff;
      res_load   = 1'b0;
      res_esc_in = 1'b0;
      res_idx_in = '0;
      res_mag_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               x_in     = sat_in(req_tdata[31:0]);
               y_in     = sat_in(req_tdata[63:32]);
               cnt_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            start_in = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (upd_status.valid) begin
               if (done_esc) begin
                  res_load   = 1'b1;
                  res_esc_in = 1'b1;
                  res_idx_in = cnt_ff - 1'b1;
                  res_mag_in = upd_status.mag;
                  state_in   = ST_SEND;
               end else if (done_bnd) begin
                  res_load = 1'b1;
                  state_in = ST_SEND;
               end else begin
                  x_in     = upd_nx;
                  y_in     = upd_ny;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_SEND: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      if (req_acc) begin
         cr_ff <= sat_in(req_tdata[95:64]);
         ci_ff <= sat_in(req_tdata[127:96]);
      end
      if (state_ff == ST_PREP) begin
         ax_ff  <= x_ff[WORD_BITS-1] ? WORD_BITS'(-x_ff) : WORD_BITS'(x_ff);
         ay_ff  <= y_ff[WORD_BITS-1] ? WORD_BITS'(-y_ff) : WORD_BITS'(y_ff);
         neg_ff <= x_ff[WORD_BITS-1] ^ y_ff[WORD_BITS-1];
      end
      if (res_load) begin
         res_esc_ff <= res_esc_in;
         res_idx_ff <= res_idx_in;
         res_mag_ff <= res_mag_in;
      end
   end

   // ---------------------------------------------------- multiplier chain
   // Each cell adds the partial products of one 16-bit digit and hands the
   // running sums to its neighbor.
   assign cvld[0] = start_ff;
   assign cax[0]  = ax_ff;
   assign cay[0]  = ay_ff;
   assign csxx[0] = '0;
   assign csyy[0] = '0;
   assign csxy[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      cmet_cell #(
         .WORD_BITS (WORD_BITS),
         .LOW_BIT   (k * DIGIT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vld_in  (cvld[k]),
         .ax_in   (cax[k]),
         .ay_in   (cay[k]),
         .sxx_in  (csxx[k]),
         .syy_in  (csyy[k]),
         .sxy_in  (csxy[k]),
         .vld_out (cvld[k+1]),
         .ax_out  (cax[k+1]),
         .ay_out  (cay[k+1]),
         .sxx_out (csxx[k+1]),
         .syy_out (csyy[k+1]),
         .sxy_out (csxy[k+1])
      );
   end

   cmet_update #(
      .WORD_BITS     (WORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_update (
      .clock   (clock),
      .reset   (reset),
      .vld_in  (cvld[NCELL]),
      .sxx_in  (csxx[NCELL]),
      .syy_in  (csyy[NCELL]),
      .sxy_in  (csxy[NCELL]),
      .neg_in  (neg_ff),
      .cr_in   (cr_ff),
      .ci_in   (ci_ff),
      .status  (upd_status),
      .nx_out  (upd_nx),
      .ny_out  (upd_ny)
   );

   // ------------------------------------------------------ output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_esc_ff <= res_esc_ff;
         rsp_idx_ff <= res_idx_ff;
         rsp_mag_ff <= res_mag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mag_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_esc_ff;

   // ----------------------------------------------------------- assertions
   // Only one pass is ever in flight through the chain and update stages.
   `CMET_ASSERT_IMP(a_one_pass, clock, reset, 1'b1, $onehot0({cvld, upd_status.valid}))
   // Update results arrive only while the controller waits for them.
   `CMET_ASSERT_IMP(a_status_in_run, clock, reset, upd_status.valid, state_ff == ST_RUN)
   // A new result shows up only after the controller handed one over.
   `CMET_ASSERT_IMP(a_rsp_from_send, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_SEND))
   // A bounded point reports index and magnitude of zero.
   `CMET_ASSERT_IMP(a_bounded_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

endmodule

`default_nettype wire
